### hdl/rssf_pkg.sv
// Shared types and constants for the ring and sector sky fraction histogram.
package rssf_pkg;

  // Field and register widths fixed by the interface.
  localparam int SKY_W    = 8;
  localparam int CODE_W   = 4;
  localparam int CFG_W    = 4;
  localparam int CFG_IDX_W = 1;
  localparam int BIN_W    = 6;
  localparam int FRAC_W   = 17;

  // Per-bin counters saturate at all ones.
  localparam int COUNT_W  = 21;
  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  // The divider produces one quotient bit per step.
  localparam int DIV_STEPS = FRAC_W;
  localparam int STEP_W    = $clog2(DIV_STEPS);

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_RING_COUNT   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_SECTOR_COUNT = 1'b1;

  localparam logic [CFG_W-1:0] CFG_COUNT_RESET = 4'd8;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DRAIN,
    ST_READ,
    ST_LOAD,
    ST_DIV,
    ST_EMIT
  } rssf_state_t;

endpackage

### hdl/rssf_div.sv
// Restoring divider giving floor(sky * 65536 / total) one quotient bit per cycle.
module rssf_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [rssf_pkg::COUNT_W-1:0]  dividend,
  input  logic [rssf_pkg::COUNT_W-1:0]  divisor,
  output logic                          done,
  output logic [rssf_pkg::FRAC_W-1:0]   quotient
);
  import rssf_pkg::*;

  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(DIV_STEPS - 1);

  logic                run_r;
  logic                done_r;
  logic [STEP_W-1:0]   step_r;
  logic [COUNT_W-1:0]  rem_r;
  logic [COUNT_W-1:0]  div_r;
  logic [FRAC_W-1:0]   quo_r;

  logic [COUNT_W:0]    shifted;
  logic                ge;
  logic [COUNT_W:0]    diff;

  // The first step tests the unshifted remainder (the integer bit of the
  // quotient); each later step shifts one fractional bit in.
  always_comb begin
    if (step_r == '0) begin
      shifted = {1'b0, rem_r};
    end else begin
      shifted = {rem_r, 1'b0};
    end
    ge   = (div_r != '0) && (shifted >= {1'b0, div_r});
    diff = shifted - {1'b0, div_r};
  end

  // Control: run for a fixed number of steps, then flag completion.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= run_r && (step_r == LAST_STEP);
      if (start) begin
        run_r  <= 1'b1;
        step_r <= '0;
      end else if (run_r) begin
        if (step_r == LAST_STEP) begin
          run_r <= 1'b0;
        end
        step_r <= step_r + 1'b1;
      end
    end
  end

  // Datapath: remainder stays below the divisor, so it fits the count width.
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= dividend;
      div_r <= divisor;
      quo_r <= '0;
    end else if (run_r) begin
      rem_r <= ge ? diff[COUNT_W-1:0] : shifted[COUNT_W-1:0];
      quo_r <= {quo_r[FRAC_W-2:0], ge};
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

### hdl/ring_sector_sky_fraction.sv
// Top level of the ring and sector sky fraction histogram.
//
//  channel   ports                                        handshake
//  --------  -------------------------------------------  ---------------------------
//  pixel     in_sky_value in_ring_code in_sector_code      start high, busy low
//            in_last_pixel
//  result    out_bin_index out_sky_fraction out_last_bin   out_strobe, one cycle
//  config    cfg_we cfg_index cfg_wdata                    cfg_we high, no wait
//
// Pixels are taken one per cycle while busy is low; a pixel's read-modify-write
// of its bin is a two-stage path round the count memory, with forwarding for
// repeated bins. A last pixel raises busy for a drain state, then per bin a
// memory read, a load, the 17-step divider and an emit state.
// Reset clears the per-bin valid flags, which stand for cleared counts; the
// flags are also cleared at the end of each emission run. Results cannot be
// stalled: each is shown for exactly one cycle.
module ring_sector_sky_fraction #(
  parameter int MAX_RINGS   = 8,
  parameter int MAX_SECTORS = 8
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic [rssf_pkg::SKY_W-1:0]      in_sky_value,
  input  logic [rssf_pkg::CODE_W-1:0]     in_ring_code,
  input  logic [rssf_pkg::CODE_W-1:0]     in_sector_code,
  input  logic                            in_last_pixel,
  output logic                            out_strobe,
  output logic [rssf_pkg::BIN_W-1:0]      out_bin_index,
  output logic [rssf_pkg::FRAC_W-1:0]     out_sky_fraction,
  output logic                            out_last_bin,
  input  logic                            cfg_we,
  input  logic [rssf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rssf_pkg::CFG_W-1:0]      cfg_wdata
);
  import rssf_pkg::*;

  localparam int DEPTH   = MAX_RINGS * MAX_SECTORS;
  localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int RING_W  = $clog2(MAX_RINGS + 1);
  localparam int SECT_W  = $clog2(MAX_SECTORS + 1);
  localparam int ENTRY_W = 2 * COUNT_W;

  function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
    sat_inc = (v == COUNT_MAX) ? COUNT_MAX : v + 1'b1;
  endfunction

  // Configuration registers.
  logic [CFG_W-1:0] ring_count_r;
  logic [CFG_W-1:0] sector_count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ring_count_r   <= CFG_COUNT_RESET;
      sector_count_r <= CFG_COUNT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_RING_COUNT:   ring_count_r   <= cfg_wdata;
        CFG_SECTOR_COUNT: sector_count_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Counts in use, held within one and the maximum.
  logic [RING_W-1:0] rings;
  logic [SECT_W-1:0] sectors;
  logic [ADDR_W-1:0] last_bin_addr;

  always_comb begin
    if (ring_count_r == '0) begin
      rings = RING_W'(1);
    end else if (int'(ring_count_r) > MAX_RINGS) begin
      rings = RING_W'(MAX_RINGS);
    end else begin
      rings = RING_W'(ring_count_r);
    end
    if (sector_count_r == '0) begin
      sectors = SECT_W'(1);
    end else if (int'(sector_count_r) > MAX_SECTORS) begin
      sectors = SECT_W'(MAX_SECTORS);
    end else begin
      sectors = SECT_W'(sector_count_r);
    end
    last_bin_addr = ADDR_W'(int'(rings) * int'(sectors) - 1);
  end

  // Sequencer state and handshake.
  rssf_state_t state_r;
  rssf_state_t state_nxt;
  logic        accept;
  logic        pix_in_range;
  logic [ADDR_W-1:0] pix_bin;
  logic [ADDR_W-1:0] bin_cnt_r;
  logic        div_start;
  logic        div_done;
  logic [FRAC_W-1:0] div_quo;
  logic        emit;
  logic        run_end;

  assign accept = start && !busy;

  // Bin of the incoming pixel; codes of zero or above the count are ignored.
  always_comb begin
    pix_in_range = (in_ring_code != '0) && (int'(in_ring_code) <= int'(rings)) &&
                   (in_sector_code != '0) && (int'(in_sector_code) <= int'(sectors));
    pix_bin = ADDR_W'((int'(in_ring_code) - 1) * int'(sectors) +
                      (int'(in_sector_code) - 1));
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (accept && in_last_pixel) state_nxt = ST_DRAIN;
      ST_DRAIN: state_nxt = ST_READ;
      ST_READ:  state_nxt = ST_LOAD;
      ST_LOAD:  state_nxt = ST_DIV;
      ST_DIV:   if (div_done) state_nxt = ST_EMIT;
      ST_EMIT:  state_nxt = (bin_cnt_r == last_bin_addr) ? ST_IDLE : ST_READ;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    busy      = 1'b1;
    div_start = 1'b0;
    emit      = 1'b0;
    run_end   = 1'b0;
    case (state_r)
      ST_IDLE: busy = 1'b0;
      ST_LOAD: div_start = 1'b1;
      ST_EMIT: begin
        emit    = 1'b1;
        run_end = (bin_cnt_r == last_bin_addr);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      bin_cnt_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_DRAIN || run_end) begin
        bin_cnt_r <= '0;
      end else if (emit) begin
        bin_cnt_r <= bin_cnt_r + 1'b1;
      end
    end
  end

  // Count memory: each entry holds the sky count above the total count.
  logic [ENTRY_W-1:0] cnt_mem [DEPTH];
  logic [ENTRY_W-1:0] rd_data_r;
  logic [ADDR_W-1:0]  rd_addr;
  logic               wr_en;
  logic [ENTRY_W-1:0] wr_data;

  // Second stage of the pixel update.
  logic               s1_vld_r;
  logic [ADDR_W-1:0]  s1_bin_r;
  logic               s1_sky_r;
  logic               fw_vld_r;
  logic [ADDR_W-1:0]  fw_bin_r;
  logic [ENTRY_W-1:0] fw_data_r;
  logic [DEPTH-1:0]   valid_r;
  logic [ENTRY_W-1:0] s1_cur;
  logic [COUNT_W-1:0] cur_sky;
  logic [COUNT_W-1:0] cur_total;

  assign rd_addr = (state_r == ST_IDLE) ? pix_bin : bin_cnt_r;

  always_ff @(posedge clk) begin
    rd_data_r <= cnt_mem[rd_addr];
    if (wr_en) begin
      cnt_mem[s1_bin_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      fw_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= accept && pix_in_range;
      fw_vld_r <= wr_en;
    end
  end

  always_ff @(posedge clk) begin
    s1_bin_r  <= pix_bin;
    s1_sky_r  <= (in_sky_value != '0);
    fw_bin_r  <= s1_bin_r;
    fw_data_r <= wr_data;
  end

  // The write at the edge of the read is not yet in the memory data: forward it.
  always_comb begin
    if (fw_vld_r && (fw_bin_r == s1_bin_r)) begin
      s1_cur = fw_data_r;
    end else if (valid_r[s1_bin_r]) begin
      s1_cur = rd_data_r;
    end else begin
      s1_cur = '0;
    end
    cur_sky   = s1_cur[ENTRY_W-1:COUNT_W];
    cur_total = s1_cur[COUNT_W-1:0];
    wr_en     = s1_vld_r;
    wr_data   = {(s1_sky_r ? sat_inc(cur_sky) : cur_sky), sat_inc(cur_total)};
  end

  // Valid flags: set on write, all cleared at reset and after each run.
  always_ff @(posedge clk) begin
    if (!rst_n || run_end) begin
      valid_r <= '0;
    end else if (wr_en) begin
      valid_r[s1_bin_r] <= 1'b1;
    end
  end

  // Emission: an entry never written reads as zero counts.
  logic [ENTRY_W-1:0] em_entry;

  assign em_entry = valid_r[bin_cnt_r] ? rd_data_r : '0;

  rssf_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (em_entry[ENTRY_W-1:COUNT_W]),
    .divisor  (em_entry[COUNT_W-1:0]),
    .done     (div_done),
    .quotient (div_quo)
  );

  // Result ports.
  assign out_strobe       = emit;
  assign out_bin_index    = BIN_W'(bin_cnt_r);
  assign out_sky_fraction = div_quo;
  assign out_last_bin     = run_end;

endmodule
